// ===== src/qsd_pkg.sv =====
// package for the query string splitter and percent decoder
// types, character constants and hex helpers; no dependencies
package qsd_pkg;

  localparam int unsigned MaxRes = 5;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  localparam logic [7:0] CharPct = 8'h25;
  localparam logic [7:0] CharEq  = 8'h3D;
  localparam logic [7:0] CharAmp = 8'h26;
  localparam logic [3:0] HexTen  = 4'd10;

  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPct   = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_part;
    logic       token_end;
    logic       pair_end;
    logic       last;
  } qsd_result_t;

  typedef struct packed {
    logic [CntW-1:0]                count;
    qsd_result_t [MaxRes-1:0]       res;
  } qsd_burst_t;

  function automatic logic hex_valid(logic [7:0] b);
    logic r;
    r = ((b >= 8'h30) && (b <= 8'h39)) ||
        ((b >= 8'h41) && (b <= 8'h46)) ||
        ((b >= 8'h61) && (b <= 8'h66));
    return r;
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] b);
    logic [3:0] r;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      r = 4'(b - 8'h30);
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      r = 4'(b - 8'h41) + HexTen;
    end else begin
      r = 4'(b - 8'h61) + HexTen;
    end
    return r;
  endfunction

  function automatic qsd_burst_t put(qsd_burst_t bst, logic [7:0] b, logic has,
                                     logic part, logic tend, logic pend);
    qsd_burst_t r;
    r = bst;
    if (r.count < CntW'(MaxRes)) begin
      r.res[r.count[$clog2(MaxRes)-1:0]] = '{out_byte: b, has_byte: has, token_part: part,
                                            token_end: tend, pair_end: pend, last: 1'b0};
      r.count = CntW'(r.count + CntW'(1));
    end
    return r;
  endfunction

endpackage

// ===== src/qsd_decoder.sv =====
// token splitter and percent decoder: parse state plus one-beat result list
// depends on qsd_pkg
module qsd_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        query_byte_i,
  input  logic              end_of_string_i,
  output qsd_pkg::qsd_burst_t burst_o
);

  logic       in_value_q, in_value_d;
  logic       pair_open_q, pair_open_d;
  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0] pend_dig_q, pend_dig_d;

  function automatic qsd_pkg::qsd_burst_t flush(qsd_pkg::qsd_burst_t bst, logic [1:0] pc,
                                                logic [7:0] pd, logic part);
    qsd_pkg::qsd_burst_t r;
    r = bst;
    if (pc != qsd_pkg::PendNone) r = qsd_pkg::put(r, qsd_pkg::CharPct, 1'b1, part, 1'b0, 1'b0);
    if (pc[1]) r = qsd_pkg::put(r, pd, 1'b1, part, 1'b0, 1'b0);
    return r;
  endfunction

  always_comb begin
    qsd_pkg::qsd_burst_t bst;
    logic take;
    bst         = '0;
    take        = 1'b1;
    in_value_d  = in_value_q;
    pair_open_d = pair_open_q;
    pend_cnt_d  = pend_cnt_q;
    pend_dig_d  = pend_dig_q;
    if (query_byte_i == qsd_pkg::CharAmp) begin
      bst         = flush(bst, pend_cnt_d, pend_dig_d, in_value_d);
      pend_cnt_d  = qsd_pkg::PendNone;
      bst         = qsd_pkg::put(bst, 8'h00, 1'b0, in_value_d, 1'b1, 1'b1);
      in_value_d  = 1'b0;
      pair_open_d = 1'b0;
    end else if ((query_byte_i == qsd_pkg::CharEq) && !in_value_d) begin
      bst         = flush(bst, pend_cnt_d, pend_dig_d, in_value_d);
      pend_cnt_d  = qsd_pkg::PendNone;
      bst         = qsd_pkg::put(bst, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      in_value_d  = 1'b1;
      pair_open_d = 1'b1;
    end else begin
      if (pend_cnt_d == qsd_pkg::PendPct) begin
        if (qsd_pkg::hex_valid(query_byte_i)) begin
          pend_dig_d = query_byte_i;
          pend_cnt_d = qsd_pkg::PendDigit;
          take       = 1'b0;
        end else begin
          bst        = flush(bst, pend_cnt_d, pend_dig_d, in_value_d);
          pend_cnt_d = qsd_pkg::PendNone;
        end
      end else if (pend_cnt_d[1]) begin
        if (qsd_pkg::hex_valid(pend_dig_d) && qsd_pkg::hex_valid(query_byte_i)) begin
          bst = qsd_pkg::put(bst, {qsd_pkg::hex_val(pend_dig_d), qsd_pkg::hex_val(query_byte_i)},
                             1'b1, in_value_d, 1'b0, 1'b0);
          pend_cnt_d = qsd_pkg::PendNone;
          take       = 1'b0;
        end else begin
          bst        = flush(bst, pend_cnt_d, pend_dig_d, in_value_d);
          pend_cnt_d = qsd_pkg::PendNone;
        end
      end
      if (take) begin
        if (query_byte_i == qsd_pkg::CharPct) begin
          pend_cnt_d = qsd_pkg::PendPct;
        end else begin
          bst = qsd_pkg::put(bst, query_byte_i, 1'b1, in_value_d, 1'b0, 1'b0);
        end
      end
      pair_open_d = 1'b1;
    end
    if (end_of_string_i) begin
      if (pair_open_d) begin
        bst = flush(bst, pend_cnt_d, pend_dig_d, in_value_d);
        bst = qsd_pkg::put(bst, 8'h00, 1'b0, in_value_d, 1'b1, 1'b1);
      end
      in_value_d  = 1'b0;
      pair_open_d = 1'b0;
      pend_cnt_d  = qsd_pkg::PendNone;
    end
    for (int i = 0; i < qsd_pkg::MaxRes; i++) begin
      bst.res[i].last = (bst.count == qsd_pkg::CntW'(i + 1));
    end
    burst_o = bst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q  <= 1'b0;
      pair_open_q <= 1'b0;
      pend_cnt_q  <= qsd_pkg::PendNone;
      pend_dig_q  <= 8'h00;
    end else if (accept_i) begin
      in_value_q  <= in_value_d;
      pair_open_q <= pair_open_d;
      pend_cnt_q  <= pend_cnt_d;
      pend_dig_q  <= pend_dig_d;
    end
  end

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3) else $error("pending count out of range");

endmodule

// ===== src/qsd_burst.sv =====
// result list register and output register, one result beat per cycle while the output is not stalled
// depends on qsd_pkg
module qsd_burst (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  qsd_pkg::qsd_burst_t burst_i,
  output logic                ready_o,
  output logic                out_valid_o,
  output qsd_pkg::qsd_result_t out_res_o,
  input  logic                out_ready_i
);

  localparam int unsigned IdxW = $clog2(qsd_pkg::MaxRes);

  qsd_pkg::qsd_result_t [qsd_pkg::MaxRes-1:0] list_q;
  logic [qsd_pkg::CntW-1:0] cnt_q;
  logic [IdxW-1:0]          idx_q;
  logic                     out_valid_q;
  qsd_pkg::qsd_result_t     out_res_q;

  logic out_free, buf_has, move, load;

  assign out_free = !out_valid_q || out_ready_i;
  assign buf_has  = (cnt_q != '0);
  assign move     = buf_has && out_free;
  assign ready_o  = !buf_has || (move && (cnt_q == qsd_pkg::CntW'(1)));
  assign load     = accept_i && (burst_i.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cnt_q <= burst_i.count;
        idx_q <= '0;
      end else if (move) begin
        cnt_q <= qsd_pkg::CntW'(cnt_q - qsd_pkg::CntW'(1));
        idx_q <= IdxW'(idx_q + IdxW'(1));
      end
      if (out_free) begin
        out_valid_q <= buf_has;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) list_q <= burst_i.res;
    if (out_free) out_res_q <= list_q[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= qsd_pkg::CntW'(qsd_pkg::MaxRes)) else $error("result count out of range");
  a_move_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q) else $error("moved result not presented");
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cnt_q == $past(burst_i.count))) else $error("list count not loaded");

endmodule

// ===== src/query_string_splitter_decoder.sv =====
// top level of the query string splitter and percent decoder
// depends on qsd_pkg, qsd_decoder, qsd_burst
//
// channel  dir  tdata           tuser                                   tlast
// s_axis   in   query_byte[7:0] -                                       end_of_string
// m_axis   out  out_byte[7:0]   pair_end,token_end,token_part,has_byte  last
//
// one input beat per cycle when each byte gives at most one result and the output is not stalled
// a byte giving more than one result holds the input while the list drains
// the first result of an input beat is registered in the result list and then in the output register
// reset clears parse state, result list count and output valid
// a stalled output holds the last beat of one list while the next byte is taken and its list loaded
module query_string_splitter_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // query_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_byte[7:0]
  output logic [3:0] m_axis_tuser,  // pair_end, token_end, token_part, has_byte
  output logic       m_axis_tlast
);

  qsd_pkg::qsd_burst_t  burst;
  qsd_pkg::qsd_result_t res;
  logic                 accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  qsd_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .query_byte_i    (s_axis_tdata),
    .end_of_string_i (s_axis_tlast),
    .burst_o         (burst)
  );

  qsd_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .burst_i     (burst),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tuser = {res.pair_end, res.token_end, res.token_part, res.has_byte};
  assign m_axis_tlast = res.last;

endmodule

// ===== verif/tb_top.sv =====
// testbench for query_string_splitter_decoder: random and directed query strings
// are streamed in and every output beat is checked against an in-bench predictor
// depends on qsd_pkg and the query_string_splitter_decoder rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 360;
  localparam int unsigned HoldStart  = 150;
  localparam int unsigned HoldLen    = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } query_item_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // query_byte[7:0]
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // out_byte[7:0]
  logic [3:0] m_axis_tuser;          // pair_end, token_end, token_part, has_byte
  logic       m_axis_tlast;

  query_item_t          query_bytes_q[$];
  qsd_pkg::qsd_result_t expected_beats[$];
  qsd_pkg::qsd_result_t burst_r[qsd_pkg::MaxRes];
  qsd_pkg::qsd_result_t want;
  query_item_t nxt;
  int          burst_n;
  int          errors = 0;
  int          items_in = 0;
  int          total_items = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  logic        hold_off = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;

  logic        in_value;
  logic        pair_open;
  logic [1:0]  esc_cnt;
  logic [7:0]  esc_digit;

  query_string_splitter_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] nib(logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else begin
      v = 4'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

  task automatic add_res(logic [7:0] b, logic has, logic part, logic tend, logic pend);
    if (burst_n < qsd_pkg::MaxRes) begin
      burst_r[burst_n] = '{out_byte: b, has_byte: has, token_part: part,
                           token_end: tend, pair_end: pend, last: 1'b0};
      burst_n++;
    end
  endtask

  task automatic flush_escape();
    if (esc_cnt >= qsd_pkg::PendPct) add_res(qsd_pkg::CharPct, 1'b1, in_value, 1'b0, 1'b0);
    if (esc_cnt >= qsd_pkg::PendDigit) add_res(esc_digit, 1'b1, in_value, 1'b0, 1'b0);
    esc_cnt = qsd_pkg::PendNone;
  endtask

  task automatic feed_token_byte(logic [7:0] b);
    if (esc_cnt == qsd_pkg::PendPct) begin
      if (is_hex(b)) begin
        esc_digit = b;
        esc_cnt = qsd_pkg::PendDigit;
        return;
      end
      flush_escape();
    end else if (esc_cnt >= qsd_pkg::PendDigit) begin
      if (is_hex(esc_digit) && is_hex(b)) begin
        add_res({nib(esc_digit), nib(b)}, 1'b1, in_value, 1'b0, 1'b0);
        esc_cnt = qsd_pkg::PendNone;
        return;
      end
      flush_escape();
    end
    if (b == qsd_pkg::CharPct) begin
      esc_cnt = qsd_pkg::PendPct;
    end else begin
      add_res(b, 1'b1, in_value, 1'b0, 1'b0);
    end
  endtask

  task automatic predict_split(logic [7:0] b, logic eos);
    burst_n = 0;
    if (b == qsd_pkg::CharAmp) begin
      flush_escape();
      add_res(8'h00, 1'b0, in_value, 1'b1, 1'b1);
      in_value = 1'b0;
      pair_open = 1'b0;
    end else if (b == qsd_pkg::CharEq && !in_value) begin
      flush_escape();
      add_res(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      in_value = 1'b1;
      pair_open = 1'b1;
    end else begin
      feed_token_byte(b);
      pair_open = 1'b1;
    end
    if (eos) begin
      if (pair_open) begin
        flush_escape();
        add_res(8'h00, 1'b0, in_value, 1'b1, 1'b1);
      end
      in_value = 1'b0;
      pair_open = 1'b0;
      esc_cnt = qsd_pkg::PendNone;
    end
    if (burst_n > 0) burst_r[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) expected_beats.push_back(burst_r[i]);
  endtask

  function automatic int next_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == qsd_pkg::CharAmp || c == qsd_pkg::CharEq || c == qsd_pkg::CharPct)
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  task automatic add_byte(logic [7:0] b, logic eos);
    query_bytes_q.push_back('{b: b, eos: eos});
  endtask

  task automatic add_token(bit is_value);
    int len;
    int pick;
    len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_byte(plain_byte(), 1'b0);
      end else if (pick < 6) begin
        add_byte(hex_char(), 1'b0);
      end else if (pick < 8) begin
        add_byte(qsd_pkg::CharPct, 1'b0);
        add_byte(hex_char(), 1'b0);
        add_byte(hex_char(), 1'b0);
      end else if (pick == 8) begin
        add_byte(qsd_pkg::CharPct, 1'b0);
        if ($urandom_range(0, 1)) add_byte(hex_char(), 1'b0);
        add_byte($urandom_range(0, 1) ? plain_byte() : qsd_pkg::CharPct, 1'b0);
      end else begin
        add_byte(is_value ? qsd_pkg::CharEq : qsd_pkg::CharPct, 1'b0);
      end
    end
  endtask

  task automatic add_query();
    int npairs;
    int start;
    query_item_t tail;
    start = query_bytes_q.size();
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      add_token(1'b0);
      if ($urandom_range(0, 3) != 0) begin
        add_byte(qsd_pkg::CharEq, 1'b0);
        add_token(1'b1);
      end
      if (p < npairs - 1) add_byte(qsd_pkg::CharAmp, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) add_byte(qsd_pkg::CharAmp, 1'b0);
    if (query_bytes_q.size() == start) begin
      add_byte(qsd_pkg::CharAmp, 1'b1);
    end else if ($urandom_range(0, 7) != 0) begin
      tail = query_bytes_q.pop_back();
      tail.eos = 1'b1;
      query_bytes_q.push_back(tail);
    end
  endtask

  // stimulus
  initial begin
    int cycles;
    int n;
    add_byte("a", 1'b0);
    add_byte(qsd_pkg::CharEq, 1'b0);
    add_byte(qsd_pkg::CharEq, 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte("4", 1'b0);
    add_byte("1", 1'b0);
    add_byte(qsd_pkg::CharAmp, 1'b0);
    add_byte(qsd_pkg::CharAmp, 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte("4", 1'b0);
    add_byte("f", 1'b0);
    add_byte(qsd_pkg::CharEq, 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte("0", 1'b0);
    add_byte("0", 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte("A", 1'b0);
    add_byte("g", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(qsd_pkg::CharPct, 1'b0);
    add_byte("7", 1'b0);
    add_byte(qsd_pkg::CharAmp, 1'b1);
    add_byte(qsd_pkg::CharPct, 1'b1);
    n = query_bytes_q.size() + RandItems;
    while (query_bytes_q.size() < n) begin
      if ($urandom_range(0, 9) < 8) begin
        add_query();
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(1, 255)),
                                               $urandom_range(0, 7) == 0);
      end
    end
    total_items = query_bytes_q.size();

    cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while ((items_in < total_items || expected_beats.size() != 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
      $display("TEST FAILED");
    end else begin
      repeat (20) @(posedge clk_i);
      if (expected_beats.size() != 0) errors++;
      if (errors == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      send_gap = 0;
      in_value = 1'b0;
      pair_open = 1'b0;
      esc_cnt = qsd_pkg::PendNone;
      esc_digit = 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_split(s_axis_tdata, s_axis_tlast);
        items_in++;
        send_gap = next_gap(send_calm);
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered beat
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (query_bytes_q.size() > 0) begin
        nxt = query_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.b;
        s_axis_tlast  <= nxt.eos;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off  <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (!hold_off && !hold_done && items_in >= HoldStart) begin
      hold_off <= 1'b1;
      hold_cnt <= HoldLen;
    end else if (hold_off) begin
      if (hold_cnt <= 1) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat expected none actual data %0h user %0h last %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_byte", want.out_byte, m_axis_tdata);
          check_field("has_byte", 8'(want.has_byte), 8'(m_axis_tuser[0]));
          check_field("token_part", 8'(want.token_part), 8'(m_axis_tuser[1]));
          check_field("token_end", 8'(want.token_end), 8'(m_axis_tuser[2]));
          check_field("pair_end", 8'(want.pair_end), 8'(m_axis_tuser[3]));
          check_field("last", 8'(want.last), 8'(m_axis_tlast));
        end
        recv_gap = next_gap(recv_calm);
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

endmodule

// ===== query_string_splitter_decoder.f =====
src/qsd_pkg.sv
src/qsd_decoder.sv
src/qsd_burst.sv
src/query_string_splitter_decoder.sv
verif/tb_top.sv
